>>> hdl/dbwu_pkg.sv
// Shared types and constants for the breakpoint and watch unit.
`timescale 1ns / 1ps

package dbwu_pkg;

  localparam int DEF_NUM_BREAKPOINTS = 4;
  localparam int DEF_NUM_WATCHES     = 2;
  localparam int DEF_COUNT_BITS      = 48;

  localparam int NUM_SLOT_REGS = 4;
  localparam int WATCH_INPUTS  = 2;
  localparam int CFG_ADDR_W    = 2;
  localparam int VALUE_W       = 48;
  localparam int SLOT_W        = 51;
  localparam int REQ_W         = 2;
  localparam int ADDR_W        = 16;
  localparam int BYTE_W        = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CHECK  = 2'd0,
    REQ_CYCLES = 2'd1,
    REQ_TOGGLE = 2'd2,
    REQ_STEP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    BP_INSTR = 2'd0,
    BP_ADDR  = 2'd1,
    BP_CYCLE = 2'd2,
    BP_NONE  = 2'd3
  } bp_kind_e;

  typedef struct packed {
    logic               en;
    bp_kind_e           kind;
    logic [VALUE_W-1:0] value;
  } bp_slot_t;

  typedef struct packed {
    req_e              req;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] cyc_add;
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
  } ev_t;

  typedef struct packed {
    logic proceed;
    logic paused;
  } res_t;

endpackage

>>> hdl/dbwu_bp_match.sv
// Parallel breakpoint comparators for all active slots.
`timescale 1ns / 1ps

module dbwu_bp_match import dbwu_pkg::*; #(
  parameter int NUM_SLOTS  = DEF_NUM_BREAKPOINTS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  bp_slot_t [NUM_SLOTS-1:0]  slots_i,
  input  logic [NUM_SLOTS-1:0]      armed_i,
  input  logic [COUNT_BITS-1:0]     instr_next_i,
  input  logic [COUNT_BITS-1:0]     cycle_total_i,
  input  logic [ADDR_W-1:0]         addr_i,
  output logic                      hit_o,
  output logic [NUM_SLOTS-1:0]      cyc_hit_o
);

  logic [NUM_SLOTS-1:0] match;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      match[s]     = 1'b0;
      cyc_hit_o[s] = 1'b0;
      if (slots_i[s].en && armed_i[s]) begin
        case (slots_i[s].kind)
          BP_INSTR: match[s] = (slots_i[s].value == VALUE_W'(instr_next_i));
          BP_ADDR:  match[s] = (slots_i[s].value == VALUE_W'(addr_i));
          BP_CYCLE: begin
            cyc_hit_o[s] = (slots_i[s].value <= VALUE_W'(cycle_total_i));
            match[s]     = cyc_hit_o[s];
          end
          default: match[s] = 1'b0;
        endcase
      end
    end
  end

  assign hit_o = |match;

endmodule

>>> hdl/dbwu_run_ctrl.sv
// Run-control state: slot registers, counters, pause and step flags, watch snapshots.
`timescale 1ns / 1ps

module dbwu_run_ctrl import dbwu_pkg::*; #(
  parameter int NUM_SLOTS  = DEF_NUM_BREAKPOINTS,
  parameter int NUM_WATCH  = DEF_NUM_WATCHES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [SLOT_W-1:0]     cfg_wdata_i,
  input  logic                  fire_i,
  input  ev_t                   ev_i,
  output res_t                  res_o
);

  bp_slot_t [NUM_SLOTS-1:0]         slots_q;
  logic [NUM_SLOTS-1:0]             armed_q, armed_d;
  logic [COUNT_BITS-1:0]            instr_q, instr_d, instr_next;
  logic [COUNT_BITS-1:0]            cycle_q, cycle_d;
  logic                             halted_q, halted_d;
  logic                             step_q, step_d;
  logic [NUM_WATCH-1:0][BYTE_W-1:0] snap_q, snap_d;
  logic [WATCH_INPUTS-1:0][BYTE_W-1:0] all_bytes;
  logic                             bp_hit;
  logic [NUM_SLOTS-1:0]             cyc_hit;

  assign instr_next = instr_q + COUNT_BITS'(1);
  assign all_bytes  = {ev_i.byte_b, ev_i.byte_a};

  dbwu_bp_match #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_bp_match (
    .slots_i       (slots_q),
    .armed_i       (armed_q),
    .instr_next_i  (instr_next),
    .cycle_total_i (cycle_q),
    .addr_i        (ev_i.addr),
    .hit_o         (bp_hit),
    .cyc_hit_o     (cyc_hit)
  );

  always_comb begin
    instr_d       = instr_q;
    cycle_d       = cycle_q;
    halted_d      = halted_q;
    step_d        = step_q;
    armed_d       = armed_q;
    snap_d        = snap_q;
    res_o.proceed = 1'b0;
    if (fire_i) begin
      case (ev_i.req)
        REQ_CHECK: begin
          instr_d = instr_next;
          if (!halted_q) begin
            halted_d = bp_hit;
            armed_d  = armed_q & ~cyc_hit;
            if (!bp_hit) begin
              for (int w = 0; w < NUM_WATCH; w++) begin
                if (all_bytes[w] != snap_q[w]) begin
                  halted_d  = 1'b1;
                  snap_d[w] = all_bytes[w];
                end
              end
            end
          end
          res_o.proceed = step_q || !halted_d;
          step_d        = 1'b0;
        end
        REQ_CYCLES: cycle_d  = cycle_q + COUNT_BITS'(ev_i.cyc_add);
        REQ_TOGGLE: halted_d = !halted_q;
        REQ_STEP:   step_d   = 1'b1;
        default:    step_d   = step_q;
      endcase
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (cfg_we_i && (cfg_addr_i == CFG_ADDR_W'(s))) begin
        armed_d[s] = 1'b1;
      end
    end
    res_o.paused = halted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= '0;
      armed_q  <= '1;
      instr_q  <= '0;
      cycle_q  <= '0;
      halted_q <= 1'b0;
      step_q   <= 1'b0;
      snap_q   <= '0;
    end else begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (cfg_we_i && (cfg_addr_i == CFG_ADDR_W'(s))) begin
          slots_q[s] <= bp_slot_t'(cfg_wdata_i);
        end
      end
      armed_q  <= armed_d;
      instr_q  <= instr_d;
      cycle_q  <= cycle_d;
      halted_q <= halted_d;
      step_q   <= step_d;
      snap_q   <= snap_d;
    end
  end

endmodule

>>> hdl/debug_breakpoint_watch_unit_top.sv
// Top level of the breakpoint and watch unit: input register, run control, result register.
`timescale 1ns / 1ps

// The unit takes one event per transfer and returns one result per event. An event
// is registered on entry, evaluated against all breakpoint slots and watch snapshots
// once the result register is free, and written to the result register, which holds
// it until it is taken. One event per cycle is sustained while results are taken; the
// loop that sets this is the update of counters, pause flag and slot arming.
// The user is to write breakpoint registers through the plain write port only while
// no event is in flight; the block itself does not enforce this.
module debug_breakpoint_watch_unit_top import dbwu_pkg::*; #(
  parameter int NUM_BREAKPOINTS = DEF_NUM_BREAKPOINTS,
  parameter int NUM_WATCHES     = DEF_NUM_WATCHES,
  parameter int COUNT_BITS      = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [SLOT_W-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [ADDR_W-1:0]     instr_addr_i,
  input  logic [BYTE_W-1:0]     cycle_count_add_i,
  input  logic [BYTE_W-1:0]     watch_byte_a_i,
  input  logic [BYTE_W-1:0]     watch_byte_b_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  proceed_o,
  output logic                  is_paused_o
);

  localparam int NUM_SLOTS = (NUM_BREAKPOINTS < NUM_SLOT_REGS) ? NUM_BREAKPOINTS
                                                               : NUM_SLOT_REGS;
  localparam int NUM_WATCH = (NUM_WATCHES < WATCH_INPUTS) ? NUM_WATCHES : WATCH_INPUTS;

  logic in_v_q;
  ev_t  ev_q;
  logic out_v_q;
  res_t res_q, res;
  logic advance, fire;

  assign advance    = !out_v_q || out_ready_i;
  assign fire       = in_v_q && advance;
  assign in_ready_o = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (advance) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ev_q.req     <= req_e'(req_type_i);
      ev_q.addr    <= instr_addr_i;
      ev_q.cyc_add <= cycle_count_add_i;
      ev_q.byte_a  <= watch_byte_a_i;
      ev_q.byte_b  <= watch_byte_b_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  dbwu_run_ctrl #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_WATCH  (NUM_WATCH),
    .COUNT_BITS (COUNT_BITS)
  ) u_run_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .ev_i        (ev_q),
    .res_o       (res)
  );

  assign out_valid_o = out_v_q;
  assign proceed_o   = res_q.proceed;
  assign is_paused_o = res_q.paused;

endmodule

>>> hdl/dbwu_checker.sv
// Port-level assertions for the breakpoint and watch unit, bound to the top level.
`timescale 1ns / 1ps

module dbwu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic proceed_o,
  input logic is_paused_o
);

  // The input side only stalls when a finished result is waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(proceed_o) && $stable(is_paused_o))
    else $error("stalled result changed or dropped");

  // Right after reset no result is pending and events are taken.
  a_clean_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("unit not empty after reset");

endmodule

bind debug_breakpoint_watch_unit_top dbwu_checker u_dbwu_checker (.*);

>>> sim/debug_breakpoint_watch_unit_top_test.sv
// Self-checking testbench for the breakpoint and watch unit: directed and random events.
`timescale 1ns / 1ps

module debug_breakpoint_watch_unit_top_test;
  import dbwu_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_EVENTS = 110;
  localparam int GAP_PCT = 29;
  localparam int WATCHES = (DEF_NUM_WATCHES < WATCH_INPUTS) ? DEF_NUM_WATCHES : WATCH_INPUTS;
  localparam logic [VALUE_W-1:0] CNT_MASK = {VALUE_W{1'b1}} >> (VALUE_W - DEF_COUNT_BITS);

  typedef enum int {
    SLOTS_DIRECTED,
    SLOTS_EXTREMES,
    SLOTS_RANDOM
  } slot_plan_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [SLOT_W-1:0]     cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  logic [REQ_W-1:0]      req_type = '0;
  logic [ADDR_W-1:0]     instr_addr = '0;
  logic [BYTE_W-1:0]     cyc_add = '0;
  logic [BYTE_W-1:0]     byte_a = '0;
  logic [BYTE_W-1:0]     byte_b = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic                  proceed_o;
  logic                  is_paused_o;

  debug_breakpoint_watch_unit_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type),
    .instr_addr_i      (instr_addr),
    .cycle_count_add_i (cyc_add),
    .watch_byte_a_i    (byte_a),
    .watch_byte_b_i    (byte_b),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .proceed_o         (proceed_o),
    .is_paused_o       (is_paused_o)
  );

  // Predicted run-control state.
  bp_slot_t           slot_reg [NUM_SLOT_REGS];
  logic               slot_armed [NUM_SLOT_REGS];
  logic [VALUE_W-1:0] instr_cnt;
  logic [VALUE_W-1:0] cycle_cnt;
  logic               halted;
  logic               step_pending;
  logic [BYTE_W-1:0]  watch_snap [WATCH_INPUTS];

  ev_t  pending_q [$];
  res_t status_q [$];
  int   queued_cnt = 0;
  int   taken_cnt = 0;
  int   fail_cnt = 0;
  int   result_cnt = 0;
  int   proceed_cnt = 0;
  int   paused_cnt = 0;
  int   stall_cycles = 0;
  logic in_fired = 1'b0;
  logic gaps_on = 1'b1;

  logic [ADDR_W-1:0] hot_addr [NUM_SLOT_REGS];
  logic [BYTE_W-1:0] cur_a = '0;
  logic [BYTE_W-1:0] cur_b = '0;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic res_t advance_run_control(ev_t e);
    res_t              r;
    logic              hit;
    logic [BYTE_W-1:0] seen [WATCH_INPUTS];
    int                i;
    r.proceed = 1'b0;
    seen[0] = e.byte_a;
    seen[1] = e.byte_b;
    case (e.req)
      REQ_CHECK: begin
        instr_cnt = (instr_cnt + 1'b1) & CNT_MASK;
        if (!halted) begin
          hit = 1'b0;
          for (i = 0; i < NUM_SLOT_REGS; i++) begin
            if (slot_reg[i].en && slot_armed[i]) begin
              if (slot_reg[i].kind == BP_INSTR && slot_reg[i].value == instr_cnt) begin
                hit = 1'b1;
              end else if (slot_reg[i].kind == BP_ADDR &&
                           slot_reg[i].value == {{(VALUE_W-ADDR_W){1'b0}}, e.addr}) begin
                hit = 1'b1;
              end else if (slot_reg[i].kind == BP_CYCLE && slot_reg[i].value <= cycle_cnt) begin
                hit = 1'b1;
                slot_armed[i] = 1'b0;
              end
            end
          end
          if (hit) halted = 1'b1;
        end
        if (!halted) begin
          for (i = 0; i < WATCHES; i++) begin
            if (seen[i] != watch_snap[i]) begin
              halted = 1'b1;
              watch_snap[i] = seen[i];
            end
          end
        end
        r.proceed = !halted || step_pending;
        step_pending = 1'b0;
      end
      REQ_CYCLES: cycle_cnt = (cycle_cnt + e.cyc_add) & CNT_MASK;
      REQ_TOGGLE: halted = !halted;
      default: step_pending = 1'b1;
    endcase
    r.paused = halted;
    return r;
  endfunction

  task automatic queue_event(req_e r, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] c,
                             logic [BYTE_W-1:0] ba, logic [BYTE_W-1:0] bb);
    ev_t e;
    e.req = r;
    e.addr = a;
    e.cyc_add = c;
    e.byte_a = ba;
    e.byte_b = bb;
    pending_q.push_back(e);
    queued_cnt++;
  endtask

  // Must be called at a falling edge while the unit is idle.
  task automatic program_slots(slot_plan_e plan);
    bp_slot_t v;
    int       i;
    for (i = 0; i < NUM_SLOT_REGS; i++) begin
      v = '0;
      case (plan)
        SLOTS_DIRECTED: begin
          v.en = 1'b1;
          v.kind = bp_kind_e'(i);
          case (i)
            0: v.value = 48'd3;
            1: v.value = 48'hFFFF;
            2: v.value = 48'd300;
            default: v.value = '1;
          endcase
        end
        SLOTS_EXTREMES: begin
          case (i)
            0: v = '{en: 1'b1, kind: BP_INSTR, value: '0};
            1: v = '{en: 1'b0, kind: BP_ADDR, value: '0};
            2: v = '{en: 1'b1, kind: BP_CYCLE, value: '0};
            default: v = '1;
          endcase
        end
        default: begin
          v.en = ($urandom_range(99) < 80);
          v.kind = bp_kind_e'($urandom_range(3));
          case (v.kind)
            BP_INSTR: v.value = (instr_cnt + $urandom_range(60, 1)) & CNT_MASK;
            BP_ADDR: begin
              hot_addr[i] = ADDR_W'($urandom);
              v.value = ($urandom_range(99) < 10) ? {16'($urandom), 16'($urandom), hot_addr[i]}
                                                  : {{(VALUE_W-ADDR_W){1'b0}}, hot_addr[i]};
            end
            BP_CYCLE: v.value = (cycle_cnt + $urandom_range(3000)) & CNT_MASK;
            default: v.value = {16'($urandom), $urandom};
          endcase
          if ($urandom_range(99) < 5) v.value = '1;
        end
      endcase
      cfg_we <= 1'b1;
      cfg_addr <= CFG_ADDR_W'(i);
      cfg_wdata <= v;
      slot_reg[i] = v;
      slot_armed[i] = 1'b1;
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain_events();
    while (taken_cnt != queued_cnt || status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly instruction checks with steady watch bytes, so that the unit keeps running
  // long enough to reach the breakpoints; the rest toggles, steps and adds cycles.
  task automatic queue_random_events(int n);
    int                k;
    int                roll;
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] c;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) < 7) cur_a = BYTE_W'($urandom);
      if ($urandom_range(99) < 7) cur_b = BYTE_W'($urandom);
      a = ($urandom_range(99) < 30) ? hot_addr[$urandom_range(NUM_SLOT_REGS - 1)]
                                    : ADDR_W'($urandom);
      c = ($urandom_range(99) < 10) ? 8'hFF : BYTE_W'($urandom);
      if (roll < 58) begin
        queue_event(REQ_CHECK, a, c, cur_a, cur_b);
      end else if (roll < 74) begin
        queue_event(REQ_CYCLES, a, c, BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (roll < 88) begin
        queue_event(REQ_TOGGLE, a, c, BYTE_W'($urandom), BYTE_W'($urandom));
      end else begin
        queue_event(REQ_STEP, a, c, BYTE_W'($urandom), BYTE_W'($urandom));
      end
    end
  endtask

  always @(negedge clk_i) begin : driver
    ev_t nxt;
    if (!in_valid || in_fired) begin
      if (pending_q.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        req_type <= nxt.req;
        instr_addr <= nxt.addr;
        cyc_add <= nxt.cyc_add;
        byte_a <= nxt.byte_a;
        byte_b <= nxt.byte_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
  end

  always @(posedge clk_i) begin : monitor
    ev_t  ev;
    res_t want;
    in_fired <= in_valid && in_ready_o;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        ev.req = req_e'(req_type);
        ev.addr = instr_addr;
        ev.cyc_add = cyc_add;
        ev.byte_a = byte_a;
        ev.byte_b = byte_b;
        status_q.push_back(advance_run_control(ev));
        taken_cnt++;
      end
      if (out_valid_o && out_ready) begin
        result_cnt++;
        if (proceed_o) proceed_cnt++;
        if (is_paused_o) paused_cnt++;
        if (status_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: unexpected result proceed=%0b paused=%0b",
                     $realtime, proceed_o, is_paused_o);
          end
        end else begin
          want = status_q.pop_front();
          if (proceed_o !== want.proceed || is_paused_o !== want.paused) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: mismatch on result %0d: expected proceed=%0b paused=%0b, got proceed=%0b paused=%0b",
                       $realtime, result_cnt, want.proceed, want.paused, proceed_o, is_paused_o);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles > STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, status_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    instr_cnt = '0;
    cycle_cnt = '0;
    halted = 1'b0;
    step_pending = 1'b0;
    for (p = 0; p < NUM_SLOT_REGS; p++) begin
      slot_reg[p] = '0;
      slot_armed[p] = 1'b1;
      hot_addr[p] = '0;
    end
    for (p = 0; p < WATCH_INPUTS; p++) watch_snap[p] = '0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    program_slots(SLOTS_DIRECTED);
    queue_event(REQ_CHECK, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'hFFFF, 8'hFF, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h0001, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_STEP, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h0002, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h0003, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_TOGGLE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    queue_event(REQ_CYCLES, 16'h0000, 8'hFF, 8'h00, 8'h00);
    queue_event(REQ_CYCLES, 16'h0000, 8'hFF, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h1234, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_TOGGLE, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h1235, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h1236, 8'h00, 8'hFF, 8'h00);
    queue_event(REQ_TOGGLE, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h1237, 8'h00, 8'hFF, 8'h80);
    queue_event(REQ_TOGGLE, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h0000, 8'h00, 8'hFF, 8'h80);
    queue_event(REQ_STEP, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'h8000, 8'h00, 8'hFF, 8'h80);
    queue_event(REQ_CYCLES, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_TOGGLE, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_STEP, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_STEP, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_event(REQ_CHECK, 16'hFFFF, 8'h00, 8'h00, 8'h7F);
    queue_event(REQ_TOGGLE, 16'h0000, 8'h00, 8'h00, 8'h00);
    cur_a = 8'h00;
    cur_b = 8'h7F;
    drain_events();

    for (p = 0; p < RAND_PHASES; p++) begin
      program_slots(p == 0 ? SLOTS_EXTREMES : SLOTS_RANDOM);
      gaps_on = (p != RAND_PHASES / 2);
      queue_random_events(PHASE_EVENTS);
      drain_events();
    end

    $display("Covered %0d events in %0d slot settings: %0d results, %0d allowed to proceed, %0d paused.",
             taken_cnt, RAND_PHASES + 1, result_cnt, proceed_cnt, paused_cnt);
    $display("Final counters: %0d instructions, %0d cycles; %0d failures.",
             instr_cnt, cycle_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> debug_breakpoint_watch_unit_top.f
hdl/dbwu_pkg.sv
hdl/dbwu_bp_match.sv
hdl/dbwu_run_ctrl.sv
hdl/debug_breakpoint_watch_unit_top.sv
hdl/dbwu_checker.sv
sim/debug_breakpoint_watch_unit_top_test.sv
